// File: sv/xor_sprite_framebuffer_unit_macros.svh
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer_unit_macros.svh
// Assertion macros shared by the frame buffer checker.
// ----------------------------------------------------------------------------
`ifndef XOR_SPRITE_FRAMEBUFFER_UNIT_MACROS_SVH
`define XOR_SPRITE_FRAMEBUFFER_UNIT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define XSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame buffer check failed");

// antecedent holds -> consequent holds in the next cycle
`define XSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame buffer check failed");

`endif

// File: sv/xsf_pkg.sv
// ----------------------------------------------------------------------------
// xsf_pkg
// Shared types and constants of the XOR sprite frame buffer.
// ----------------------------------------------------------------------------
package xsf_pkg;

    localparam int LANES = 8;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [3:0] row_offset;
        logic [7:0] sprite_byte;
        logic       first_row;
        logic       last_row;
    } item_t;

    typedef struct packed {
        logic       collision;
        logic       sprite_done;
        logic [7:0] pixel_byte;
    } result_t;

    typedef struct packed {
        logic pix;
        logic old;
        logic hit;
    } lane_t;

    typedef struct packed {
        logic       hit_any;
        logic [7:0] pixels;
    } merge_t;

endpackage

// File: sv/xsf_frame_mem.sv
// ----------------------------------------------------------------------------
// xsf_frame_mem
// Row-wide frame store with per-row valid bits; an invalid row reads as zero.
// ----------------------------------------------------------------------------
module xsf_frame_mem #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 128,
    parameter int RW       = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [RW-1:0]       rd_addr,
    output logic [MAX_COLS-1:0] rd_row,
    input  logic                wr_en,
    input  logic [RW-1:0]       wr_addr,
    input  logic [MAX_COLS-1:0] wr_row,
    input  logic                clr
);

    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_COLS-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic [MAX_ROWS-1:0] valid_reg;
    logic [MAX_ROWS-1:0] valid_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (clr)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: sv/xsf_lane.sv
// ----------------------------------------------------------------------------
// xsf_lane
// One pixel lane: wrapped column, old pixel and collision for one sprite bit.
// ----------------------------------------------------------------------------
module xsf_lane #(
    parameter int MAX_COLS = 128,
    parameter int CW       = 7,
    parameter int LANE     = 0
) (
    input  logic [CW-1:0]       xm,
    input  logic [CW:0]         cols,
    input  logic                pix,
    input  logic [MAX_COLS-1:0] row,
    output logic [CW-1:0]       col,
    output xsf_pkg::lane_t      stat
);

    localparam logic [CW:0] OFS = (CW+1)'(LANE);

    logic [CW:0] sum;

    // xm is already below cols and the lane offset is below 8, so one subtract wraps
    assign sum = {1'b0, xm} + OFS;
    assign col = (sum >= cols) ? CW'(sum - cols) : CW'(sum);

    always_comb
    begin
        stat.pix = pix;
        stat.old = row[col];
        stat.hit = pix & row[col];
    end

endmodule

// File: sv/xsf_merge.sv
// ----------------------------------------------------------------------------
// xsf_merge
// Combines the lane results: new row contents, collision and read-out byte.
// ----------------------------------------------------------------------------
module xsf_merge #(
    parameter int MAX_COLS = 128,
    parameter int CW       = 7
) (
    input  xsf_pkg::lane_t      stat [xsf_pkg::LANES],
    input  logic [CW-1:0]       col  [xsf_pkg::LANES],
    input  logic [MAX_COLS-1:0] row,
    output logic [MAX_COLS-1:0] new_row,
    output xsf_pkg::merge_t     merged
);

    always_comb
    begin
        new_row        = row;
        merged.hit_any = 1'b0;
        merged.pixels  = '0;
        for (int i = 0; i < xsf_pkg::LANES; i++)
        begin
            new_row[col[i]]                         = row[col[i]] ^ stat[i].pix;
            merged.hit_any                          = merged.hit_any | stat[i].hit;
            merged.pixels[xsf_pkg::LANES - 1 - i]   = stat[i].old;
        end
    end

endmodule

// File: sv/xor_sprite_framebuffer_unit.sv
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer_unit
// One-bit frame buffer with XOR sprite rows, clear and eight-pixel read-out.
// ----------------------------------------------------------------------------
// Use: present an item on 'item' with 'start' high; it is taken at an edge
// where 'busy' is low. Ops: clear frame, draw one sprite row, read 8 pixels.
// Each item gives one result on 'result', shown for exactly one cycle with
// 'done' high; the receiver cannot stall it.
// The result is registered at the edge that ends the busy cycle after the
// accepting edge. No new item is taken until the read-modify-write of one
// frame row is done (read at the accepting edge, eight pixel lanes plus
// write-back in the following cycle). 'busy' is high for that one cycle.
// Config: 'cfg_data' writes the display mode (0 classic, 1 super) on a
// cfg_valid/cfg_ready beat; cfg_ready is high while idle and start is low.
// A mode write clears the frame. Clears work by resetting the per-row
// valid bits.
// Reset: the frame reads as all zero, mode is classic, collision is zero;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module xor_sprite_framebuffer_unit #(
    parameter int CLASSIC_COLS = 64,
    parameter int CLASSIC_ROWS = 32,
    parameter int SUPER_COLS   = 128,
    parameter int SUPER_ROWS   = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  xsf_pkg::item_t    item,
    output logic              done,
    output xsf_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    localparam int MAX_COLS = (SUPER_COLS > CLASSIC_COLS) ? SUPER_COLS : CLASSIC_COLS;
    localparam int MAX_ROWS = (SUPER_ROWS > CLASSIC_ROWS) ? SUPER_ROWS : CLASSIC_ROWS;
    localparam int CW       = $clog2(MAX_COLS);
    localparam int RW       = $clog2(MAX_ROWS);

    localparam logic [CW:0] COLS_C = (CW+1)'(CLASSIC_COLS);
    localparam logic [CW:0] COLS_S = (CW+1)'(SUPER_COLS);
    localparam logic [RW:0] ROWS_C = (RW+1)'(CLASSIC_ROWS);
    localparam logic [RW:0] ROWS_S = (RW+1)'(SUPER_ROWS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic [CW-1:0] xmod_c [256];
    logic [CW-1:0] xmod_s [256];
    logic [RW-1:0] ymod_c [256];
    logic [RW-1:0] ymod_s [256];
    logic [RW-1:0] rmod_c [16];
    logic [RW-1:0] rmod_s [16];

    for (genvar k = 0; k < 256; k++)
    begin : g_tab8
        localparam int XC = k % CLASSIC_COLS;
        localparam int XS = k % SUPER_COLS;
        localparam int YC = k % CLASSIC_ROWS;
        localparam int YS = k % SUPER_ROWS;
        assign xmod_c[k] = CW'(XC);
        assign xmod_s[k] = CW'(XS);
        assign ymod_c[k] = RW'(YC);
        assign ymod_s[k] = RW'(YS);
    end

    for (genvar k = 0; k < 16; k++)
    begin : g_tab4
        localparam int RC = k % CLASSIC_ROWS;
        localparam int RS = k % SUPER_ROWS;
        assign rmod_c[k] = RW'(RC);
        assign rmod_s[k] = RW'(RS);
    end

    logic                state_reg;
    logic                state_next;
    logic                mode_reg;
    logic                coll_reg;
    logic                coll_next;
    logic                done_reg;
    xsf_pkg::result_t    res_reg;
    xsf_pkg::result_t    res_next;

    logic [1:0]          op_reg;
    logic [CW-1:0]       xm_reg;
    logic [7:0]          sprite_reg;
    logic                first_reg;
    logic                last_reg;
    logic [RW-1:0]       addr_reg;

    logic                accept;
    logic                cfg_fire;
    logic                run;
    logic [CW:0]         cols;
    logic [RW:0]         rows;
    logic [CW-1:0]       xm;
    logic [RW-1:0]       ym;
    logic [RW-1:0]       rm;
    logic [RW:0]         rsum;
    logic [RW-1:0]       rd_addr;
    logic [MAX_COLS-1:0] rd_row;
    logic [MAX_COLS-1:0] new_row;
    logic                clr;
    logic                wr_en;

    xsf_pkg::lane_t      stat [xsf_pkg::LANES];
    logic [CW-1:0]       col  [xsf_pkg::LANES];
    xsf_pkg::merge_t     merged;

    assign run       = (state_reg == ST_RUN);
    assign busy      = run;
    assign cfg_ready = !run && !start;
    assign accept    = start && !run;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign cols = mode_reg ? COLS_S : COLS_C;
    assign rows = mode_reg ? ROWS_S : ROWS_C;
    assign xm   = mode_reg ? xmod_s[item.x_pos] : xmod_c[item.x_pos];
    assign ym   = mode_reg ? ymod_s[item.y_pos] : ymod_c[item.y_pos];
    assign rm   = mode_reg ? rmod_s[item.row_offset] : rmod_c[item.row_offset];
    assign rsum = {1'b0, ym} + {1'b0, rm};

    always_comb
    begin
        rd_addr = ym;
        if (item.op == xsf_pkg::OP_DRAW)
        begin
            rd_addr = (rsum >= rows) ? RW'(rsum - rows) : RW'(rsum);
        end
    end

    assign wr_en = run && (op_reg == xsf_pkg::OP_DRAW);
    assign clr   = cfg_fire || (run && (op_reg == xsf_pkg::OP_CLEAR));

    xsf_frame_mem #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .RW       (RW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_row  (rd_row),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_row  (new_row),
        .clr     (clr)
    );

    for (genvar i = 0; i < xsf_pkg::LANES; i++)
    begin : g_lane
        xsf_lane #(
            .MAX_COLS (MAX_COLS),
            .CW       (CW),
            .LANE     (i)
        ) u_lane (
            .xm   (xm_reg),
            .cols (cols),
            .pix  (sprite_reg[xsf_pkg::LANES - 1 - i]),
            .row  (rd_row),
            .col  (col[i]),
            .stat (stat[i])
        );
    end

    xsf_merge #(
        .MAX_COLS (MAX_COLS),
        .CW       (CW)
    ) u_merge (
        .stat    (stat),
        .col     (col),
        .row     (rd_row),
        .new_row (new_row),
        .merged  (merged)
    );

    assign coll_next = (first_reg ? 1'b0 : coll_reg) | merged.hit_any;

    always_comb
    begin
        res_next = '0;
        unique case (op_reg)
            xsf_pkg::OP_DRAW:
            begin
                res_next.collision   = coll_next;
                res_next.sprite_done = last_reg;
            end
            xsf_pkg::OP_READ:
            begin
                res_next.pixel_byte = merged.pixels;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        if (run)
        begin
            state_next = ST_IDLE;
        end
        else if (accept)
        begin
            state_next = ST_RUN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= 1'b0;
            coll_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= run;
            if (cfg_fire)
            begin
                mode_reg <= cfg_data;
            end
            if (wr_en)
            begin
                coll_reg <= coll_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= item.op;
            xm_reg     <= xm;
            sprite_reg <= item.sprite_byte;
            first_reg  <= item.first_row;
            last_reg   <= item.last_row;
            addr_reg   <= rd_addr;
        end
        if (run)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// File: sv/xsf_checker.sv
// ----------------------------------------------------------------------------
// xsf_checker
// Port-level checks of the frame buffer's command timing and result fields.
// ----------------------------------------------------------------------------
`include "xor_sprite_framebuffer_unit_macros.svh"

module xsf_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input xsf_pkg::result_t result
);

    `XSF_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    `XSF_ASSERT_NEXT(a_busy_done, clk, rst_n, busy, !busy && done)
    `XSF_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `XSF_ASSERT_NOW(a_read_fields, clk, rst_n, done && (result.pixel_byte != 8'd0), !result.collision && !result.sprite_done)

endmodule

bind xor_sprite_framebuffer_unit xsf_checker u_xsf_checker (.*);

// File: test/xsf_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xsf_frame_checker
// Watches the item, result and mode channels of the XOR sprite frame buffer.
// It keeps its own copy of the frame, the collision flag and the display
// mode, and predicts the result of every accepted item. It then compares
// each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module xsf_frame_checker #(
    parameter int CLASSIC_COLS = 64,
    parameter int CLASSIC_ROWS = 32,
    parameter int SUPER_COLS   = 128,
    parameter int SUPER_ROWS   = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  xsf_pkg::item_t   item,
    input  logic             done,
    input  xsf_pkg::result_t result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic             cfg_data,
    output int               fails,
    output int               pending,
    output int               checked
);

    localparam int MAX_COLS = (SUPER_COLS > CLASSIC_COLS) ? SUPER_COLS : CLASSIC_COLS;
    localparam int MAX_ROWS = (SUPER_ROWS > CLASSIC_ROWS) ? SUPER_ROWS : CLASSIC_ROWS;

    logic [MAX_COLS-1:0] frame [MAX_ROWS];
    logic                super_mode;
    logic                hit_accum;
    xsf_pkg::result_t    due_results [$];

    initial
    begin
        fails   = 0;
        pending = 0;
        checked = 0;
    end

    function automatic void wipe_frame();
        for (int r = 0; r < MAX_ROWS; r++)
            frame[r] = '0;
    endfunction

    function automatic xsf_pkg::result_t frame_step(input xsf_pkg::item_t it);
        xsf_pkg::result_t res;
        int               cols;
        int               rows;
        int               r;
        int               c;
        logic             pix;
        res  = '0;
        cols = super_mode ? SUPER_COLS : CLASSIC_COLS;
        rows = super_mode ? SUPER_ROWS : CLASSIC_ROWS;
        case (it.op)
            xsf_pkg::OP_CLEAR:
                wipe_frame();
            xsf_pkg::OP_DRAW:
            begin
                r = (int'(it.y_pos) + int'(it.row_offset)) % rows;
                if (it.first_row)
                    hit_accum = 1'b0;
                for (int i = 0; i < xsf_pkg::LANES; i++)
                begin
                    c   = (int'(it.x_pos) + i) % cols;
                    pix = it.sprite_byte[xsf_pkg::LANES-1-i];
                    if (pix && frame[r][c])
                        hit_accum = 1'b1;
                    frame[r][c] = frame[r][c] ^ pix;
                end
                res.collision   = hit_accum;
                res.sprite_done = it.last_row;
            end
            xsf_pkg::OP_READ:
            begin
                r = int'(it.y_pos) % rows;
                for (int i = 0; i < xsf_pkg::LANES; i++)
                begin
                    c = (int'(it.x_pos) + i) % cols;
                    res.pixel_byte[xsf_pkg::LANES-1-i] = frame[r][c];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        xsf_pkg::result_t want;
        if (!rst_n)
        begin
            wipe_frame();
            super_mode = 1'b0;
            hit_accum  = 1'b0;
            due_results.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing due, actual %h", $time, result);
                    fails++;
                end
                else
                begin
                    want = due_results.pop_front();
                    compare_field("collision", want.collision, result.collision);
                    compare_field("sprite_done", want.sprite_done, result.sprite_done);
                    compare_field("pixel_byte", want.pixel_byte, result.pixel_byte);
                    checked++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                super_mode = cfg_data;
                wipe_frame();
            end
            if (start && !busy)
                due_results.push_back(frame_step(item));
            pending = due_results.size();
        end
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression for the XOR sprite frame buffer. Directed items cover wrapping,
// collision build-up, clears, the unused op and mode writes. Then random
// phases in both modes send well-formed sprites, reads, noise, with random
// gaps past the first. A side checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic       DISP_LORES  = 1'b0;
    localparam logic       DISP_HIRES  = 1'b1;
    localparam int         STALL_LIMIT = 2000;
    localparam int         PHASE_ITEMS = 170;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    xsf_pkg::item_t   item;
    logic             done;
    xsf_pkg::result_t result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_data;

    int      fails;
    int      pending;
    int      checked;
    int      stall_cycles = 0;
    int      n_items      = 0;
    int      n_draw       = 0;
    int      n_read       = 0;
    int      n_clear      = 0;
    int      n_unused     = 0;
    int      n_mode       = 0;
    bit      steady       = 1'b1;

    xor_sprite_framebuffer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    xsf_frame_checker frame_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending),
        .checked   (checked)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, STALL_LIMIT);
            $display("xor_sprite_framebuffer_unit regression: fail");
            $finish;
        end
    end

    function automatic xsf_pkg::item_t make_item(input logic [1:0] op, input logic [7:0] x,
                                                 input logic [7:0] y, input logic [3:0] roff,
                                                 input logic [7:0] spr, input logic first,
                                                 input logic last);
        xsf_pkg::item_t it;
        it.op          = op;
        it.x_pos       = x;
        it.y_pos       = y;
        it.row_offset  = roff;
        it.sprite_byte = spr;
        it.first_row   = first;
        it.last_row    = last;
        return it;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // clustered near the origin and both wrap edges so sprites overlap
    function automatic logic [7:0] pick_coord();
        logic [7:0] v;
        case ($urandom_range(0, 3))
            0:       v = 8'($urandom_range(0, 255));
            1:       v = 8'($urandom_range(0, 15));
            2:       v = 8'($urandom_range(56, 71));
            default: v = 8'($urandom_range(120, 135));
        endcase
        return v;
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [3:0] rnd_roff();
        return 4'($urandom_range(0, 14));
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send(input xsf_pkg::item_t it);
        logic was_busy;
        int   gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        item  = it;
        forever
        begin
            was_busy = busy;
            @(posedge clk);
            if (!was_busy)
                break;
            @(negedge clk);
        end
        @(negedge clk);
        n_items++;
        case (it.op)
            xsf_pkg::OP_CLEAR: n_clear++;
            xsf_pkg::OP_DRAW:  n_draw++;
            xsf_pkg::OP_READ:  n_read++;
            default:           n_unused++;
        endcase
    endtask

    task automatic drain();
        start = 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        logic was_ready;
        drain();
        cfg_valid = 1'b1;
        cfg_data  = mode;
        forever
        begin
            was_ready = cfg_ready;
            @(posedge clk);
            if (was_ready)
                break;
            @(negedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
        n_mode++;
    endtask

    initial
    begin
        int         sel;
        int         rows_in_sprite;
        int         target;
        logic [7:0] sx;
        logic [7:0] sy;
        logic       mode;

        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // classic mode after reset
        send(make_item(xsf_pkg::OP_READ,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 1'b0));
        send(make_item(xsf_pkg::OP_DRAW,  8'd60,  8'd31,  4'd1,  8'hFF, 1'b1, 1'b0));
        send(make_item(xsf_pkg::OP_DRAW,  8'd60,  8'd31,  4'd1,  8'hFF, 1'b0, 1'b1));
        send(make_item(xsf_pkg::OP_READ,  8'd60,  8'd32,  4'd14, 8'hFF, 1'b1, 1'b1));
        send(make_item(xsf_pkg::OP_DRAW,  8'd255, 8'd255, 4'd14, 8'hA5, 1'b1, 1'b1));
        send(make_item(xsf_pkg::OP_READ,  8'd255, 8'd13,  4'd7,  8'h3C, 1'b0, 1'b1));
        send(make_item(xsf_pkg::OP_DRAW,  8'd0,   8'd13,  4'd0,  8'h80, 1'b1, 1'b0));
        send(make_item(xsf_pkg::OP_DRAW,  8'd63,  8'd13,  4'd0,  8'h01, 1'b0, 1'b0));
        send(make_item(xsf_pkg::OP_DRAW,  8'd8,   8'd20,  4'd0,  8'h01, 1'b0, 1'b0));
        send(make_item(xsf_pkg::OP_CLEAR, 8'd255, 8'd255, 4'd14, 8'hFF, 1'b1, 1'b1));
        send(make_item(xsf_pkg::OP_DRAW,  8'd8,   8'd20,  4'd0,  8'h00, 1'b0, 1'b1));
        send(make_item(OP_UNUSED,         8'd255, 8'd255, 4'd14, 8'hFF, 1'b1, 1'b1));
        send(make_item(xsf_pkg::OP_READ,  8'd0,   8'd13,  4'd0,  8'h00, 1'b0, 1'b0));
        write_mode(DISP_HIRES);
        send(make_item(xsf_pkg::OP_DRAW,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 1'b1));
        send(make_item(xsf_pkg::OP_DRAW,  8'd124, 8'd63,  4'd14, 8'hC3, 1'b1, 1'b1));
        send(make_item(xsf_pkg::OP_READ,  8'd252, 8'd77,  4'd0,  8'h00, 1'b0, 1'b0));
        send(make_item(xsf_pkg::OP_DRAW,  8'd255, 8'd255, 4'd14, 8'hFF, 1'b1, 1'b0));
        send(make_item(xsf_pkg::OP_READ,  8'd120, 8'd13,  4'd0,  8'h00, 1'b0, 1'b0));
        send(make_item(xsf_pkg::OP_READ,  8'd127, 8'd141, 4'd0,  8'h00, 1'b0, 1'b0));
        write_mode(DISP_LORES);
        send(make_item(xsf_pkg::OP_READ,  8'd60,  8'd13,  4'd0,  8'h00, 1'b0, 1'b0));
        send(make_item(xsf_pkg::OP_DRAW,  8'd1,   8'd2,   4'd3,  8'h5A, 1'b0, 1'b1));

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0, 1:    mode = DISP_HIRES;
                2:       mode = DISP_LORES;
                default: mode = rnd_bit();
            endcase
            write_mode(mode);
            steady = (p == 0);
            target = n_items + PHASE_ITEMS;
            while (n_items < target)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 55)
                begin
                    rows_in_sprite = $urandom_range(1, 15);
                    sx = pick_coord();
                    sy = pick_coord();
                    for (int r = 0; r < rows_in_sprite; r++)
                        send(make_item(xsf_pkg::OP_DRAW, sx, sy, r[3:0], rnd8(),
                                       r == 0, r == rows_in_sprite - 1));
                end
                else if (sel < 82)
                    send(make_item(xsf_pkg::OP_READ, pick_coord(), pick_coord(),
                                   rnd_roff(), rnd8(), rnd_bit(), rnd_bit()));
                else if (sel < 93)
                    send(make_item(xsf_pkg::OP_DRAW, rnd8(), pick_coord(),
                                   rnd_roff(), rnd8(), rnd_bit(), rnd_bit()));
                else if (sel < 96)
                    send(make_item(xsf_pkg::OP_CLEAR, rnd8(), rnd8(),
                                   rnd_roff(), rnd8(), rnd_bit(), rnd_bit()));
                else
                    send(make_item(OP_UNUSED, rnd8(), rnd8(),
                                   rnd_roff(), rnd8(), rnd_bit(), rnd_bit()));
                if ($urandom_range(0, 49) == 0)
                    drain();
            end
        end

        start = 1'b0;
        wait (pending == 0);
        repeat (5) @(posedge clk);
        $display("covered %0d items: %0d draw rows, %0d reads, %0d clears, %0d unused ops",
                 n_items, n_draw, n_read, n_clear, n_unused);
        $display("%0d mode writes over classic and super, %0d results checked",
                 n_mode, checked);
        if (fails == 0)
            $display("xor_sprite_framebuffer_unit regression: pass");
        else
            $display("xor_sprite_framebuffer_unit regression: fail");
        $finish;
    end

endmodule
